// ===== hw/rtl/preemptive_priority_task_queue_defines.svh =====
// Assertion macros for the preemptive priority task queue.
// Used by the top level only; the bodies are empty when SYNTHESIS is defined.
`ifndef PREEMPTIVE_PRIORITY_TASK_QUEUE_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_TASK_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS

// Property must hold at every clock outside reset
`define PPTQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true outside reset
`define PPTQ_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define PPTQ_ASSERT(label, prop, msg)
`define PPTQ_ASSERT_NEVER(label, cond, msg)

`endif

`endif

// ===== hw/rtl/pptq_pkg.sv =====
// Shared constants, codes and types for the preemptive priority task queue.
// No dependencies.
package pptq_pkg;

    // Sizing
    localparam int QUEUE_DEPTH = 16;
    localparam int NEST_DEPTH  = 8;

    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int QSUM_W = QCNT_W + 1;
    localparam int NPTR_W = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int NCNT_W = $clog2(NEST_DEPTH + 1);

    localparam int LEVEL_W   = 8;
    localparam int TASK_W    = 8;
    localparam int CNT_OUT_W = 5;

    // Idle running level
    localparam logic [LEVEL_W-1:0] IDLE_LEVEL = 8'd255;

    typedef enum logic [1:0] {
        CMD_ADD      = 2'd0,
        CMD_DISPATCH = 2'd1,
        CMD_FINISH   = 2'd2,
        CMD_NOP      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_NONE    = 2'd2,
        ST_NEST    = 2'd3
    } status_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] prio;
        logic [TASK_W-1:0]  id;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_CMP,
        S_ADD_WR,
        S_DISP_WAIT,
        S_FIN_WAIT,
        S_DONE
    } state_t;

endpackage

// ===== hw/rtl/preemptive_priority_task_queue.sv =====
// Preemptive priority task queue: sorted wait queue plus nesting stack, both in memories.
// Depends on pptq_pkg and preemptive_priority_task_queue_defines.svh.
//
// One command beat is taken at a time and gives one result beat. The waiting tasks
// sit in a circular, priority-sorted queue memory with a registered read; an add to a
// non-empty queue walks from the tail toward the head, moving one entry a cycle past
// each waiting entry that is less urgent than the new task, then writes the new task.
// Dispatch and finish make one memory read. An add to an empty or full queue, a
// dispatch from an empty queue, a finish with nothing nested and the unused code go
// straight to the result state. The result sits in an output register; a result still
// held there stalls the next command. running_priority and queued_count report the
// state after the command. A running level of 255 means idle; there is no clearing
// pass after reset.
`include "preemptive_priority_task_queue_defines.svh"

module preemptive_priority_task_queue
    import pptq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // command channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           cmd,
    input  logic [TASK_W-1:0]    task_id,
    input  logic [LEVEL_W-1:0]   task_priority,
    // result channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output logic                 dispatched,
    output logic [TASK_W-1:0]    run_task_id,
    output logic [LEVEL_W-1:0]   running_priority,
    output logic [CNT_OUT_W-1:0] queued_count
);

    // Queue slot from head plus offset, wrapped once
    function automatic logic [QPTR_W-1:0] wrap_idx(input logic [QSUM_W-1:0] s);
        logic [QSUM_W-1:0] t;
        begin
            t = s;
            if (s >= QSUM_W'(QUEUE_DEPTH))
            begin
                t = s - QSUM_W'(QUEUE_DEPTH);
            end
            return t[QPTR_W-1:0];
        end
    endfunction

    state_t              state_reg, state_next;
    logic [QPTR_W-1:0]   head_reg, head_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic [QCNT_W-1:0]   k_reg, k_next;
    logic [LEVEL_W-1:0]  level_reg, level_next;
    logic [NCNT_W-1:0]   nest_reg, nest_next;
    entry_t              new_reg, new_next;
    status_t             pend_status_reg, pend_status_next;
    logic                pend_disp_reg, pend_disp_next;
    logic [TASK_W-1:0]   pend_id_reg, pend_id_next;

    logic                out_valid_reg, out_valid_next;
    logic [1:0]          out_status_reg, out_status_next;
    logic                out_disp_reg, out_disp_next;
    logic [TASK_W-1:0]   out_id_reg, out_id_next;
    logic [LEVEL_W-1:0]  out_level_reg, out_level_next;
    logic [CNT_OUT_W-1:0] out_count_reg, out_count_next;

    // Memory ports
    entry_t              q_mem [QUEUE_DEPTH];
    logic                q_we;
    logic [QPTR_W-1:0]   q_waddr, q_raddr;
    entry_t              q_wdata, q_rdata;

    logic [LEVEL_W-1:0]  s_mem [NEST_DEPTH];
    logic                s_we;
    logic [NPTR_W-1:0]   s_waddr, s_raddr;
    logic [LEVEL_W-1:0]  s_wdata, s_rdata;

    // Conditions and helpers
    logic                q_full, q_empty, n_full, n_empty, out_free, shift_up;
    logic [QCNT_W-1:0]   cnt_m1, k_m1, k_m2;
    logic [NCNT_W-1:0]   nest_m1;
    cmd_t                cmd_in;

    assign cmd_in   = cmd_t'(cmd);
    assign q_full   = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_empty  = (count_reg == '0);
    assign n_full   = (nest_reg == NCNT_W'(NEST_DEPTH));
    assign n_empty  = (nest_reg == '0);
    assign out_free = !out_valid_reg || out_ready;
    assign shift_up = (q_rdata.prio > new_reg.prio);
    assign cnt_m1   = count_reg - QCNT_W'(1);
    assign k_m1     = k_reg - QCNT_W'(1);
    assign k_m2     = k_reg - QCNT_W'(2);
    assign nest_m1  = nest_reg - NCNT_W'(1);

    // Queue memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[q_waddr] <= q_wdata;
        end
        q_rdata <= q_mem[q_raddr];
    end

    // Nesting stack memory
    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            s_mem[s_waddr] <= s_wdata;
        end
        s_rdata <= s_mem[s_raddr];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (cmd_in)
                        CMD_ADD:      state_next = (q_full || q_empty) ? S_DONE : S_ADD_CMP;
                        CMD_DISPATCH: state_next = q_empty ? S_DONE : S_DISP_WAIT;
                        CMD_FINISH:   state_next = n_empty ? S_DONE : S_FIN_WAIT;
                        default:      state_next = S_DONE;
                    endcase
                end
            end
            S_ADD_CMP:
            begin
                if (!shift_up)
                begin
                    state_next = S_DONE;
                end
                else if (k_reg == QCNT_W'(1))
                begin
                    state_next = S_ADD_WR;
                end
            end
            S_ADD_WR:    state_next = S_DONE;
            S_DISP_WAIT: state_next = S_DONE;
            S_FIN_WAIT:  state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // Datapath, memory controls and result
    always_comb
    begin
        head_next        = head_reg;
        count_next       = count_reg;
        k_next           = k_reg;
        level_next       = level_reg;
        nest_next        = nest_reg;
        new_next         = new_reg;
        pend_status_next = pend_status_reg;
        pend_disp_next   = pend_disp_reg;
        pend_id_next     = pend_id_reg;
        out_status_next  = out_status_reg;
        out_disp_next    = out_disp_reg;
        out_id_next      = out_id_reg;
        out_level_next   = out_level_reg;
        out_count_next   = out_count_reg;
        out_valid_next   = out_valid_reg && !out_ready;

        q_we    = 1'b0;
        q_waddr = head_reg;
        q_wdata = new_reg;
        q_raddr = head_reg;
        s_we    = 1'b0;
        s_waddr = nest_reg[NPTR_W-1:0];
        s_wdata = level_reg;
        s_raddr = nest_m1[NPTR_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    new_next.prio    = task_priority;
                    new_next.id      = task_id;
                    pend_status_next = ST_DONE;
                    pend_disp_next   = 1'b0;
                    pend_id_next     = '0;
                    case (cmd_in)
                        CMD_ADD:
                        begin
                            if (q_full)
                            begin
                                pend_status_next = ST_FULL;
                            end
                            else if (q_empty)
                            begin
                                q_we          = 1'b1;
                                q_wdata.prio  = task_priority;
                                q_wdata.id    = task_id;
                                count_next    = count_reg + QCNT_W'(1);
                            end
                            else
                            begin
                                // start at the tail entry
                                q_raddr = wrap_idx(QSUM_W'(head_reg) + QSUM_W'(cnt_m1));
                                k_next  = count_reg;
                            end
                        end
                        CMD_DISPATCH:
                        begin
                            if (q_empty)
                            begin
                                pend_status_next = ST_NONE;
                            end
                        end
                        CMD_FINISH:
                        begin
                            if (n_empty)
                            begin
                                pend_status_next = ST_NEST;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_ADD_CMP:
            begin
                // q_rdata holds entry k-1
                q_we    = 1'b1;
                q_waddr = wrap_idx(QSUM_W'(head_reg) + QSUM_W'(k_reg));
                if (shift_up)
                begin
                    q_wdata = q_rdata;
                    k_next  = k_m1;
                    q_raddr = wrap_idx(QSUM_W'(head_reg) + QSUM_W'(k_m2));
                end
                else
                begin
                    count_next = count_reg + QCNT_W'(1);
                end
            end
            S_ADD_WR:
            begin
                q_we       = 1'b1;
                count_next = count_reg + QCNT_W'(1);
            end
            S_DISP_WAIT:
            begin
                if (q_rdata.prio >= level_reg)
                begin
                    pend_status_next = ST_NONE;
                end
                else if (n_full)
                begin
                    pend_status_next = ST_NEST;
                end
                else
                begin
                    s_we           = 1'b1;
                    nest_next      = nest_reg + NCNT_W'(1);
                    level_next     = q_rdata.prio;
                    head_next      = wrap_idx(QSUM_W'(head_reg) + QSUM_W'(1));
                    count_next     = cnt_m1;
                    pend_disp_next = 1'b1;
                    pend_id_next   = q_rdata.id;
                end
            end
            S_FIN_WAIT:
            begin
                level_next = s_rdata;
                nest_next  = nest_m1;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_status_reg;
                    out_disp_next   = pend_disp_reg;
                    out_id_next     = pend_id_reg;
                    out_level_next  = level_reg;
                    out_count_next  = CNT_OUT_W'(count_reg);
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            level_reg     <= IDLE_LEVEL;
            nest_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            level_reg     <= level_next;
            nest_reg      <= nest_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        k_reg           <= k_next;
        new_reg         <= new_next;
        pend_status_reg <= pend_status_next;
        pend_disp_reg   <= pend_disp_next;
        pend_id_reg     <= pend_id_next;
        out_status_reg  <= out_status_next;
        out_disp_reg    <= out_disp_next;
        out_id_reg      <= out_id_next;
        out_level_reg   <= out_level_next;
        out_count_reg   <= out_count_next;
    end

    assign in_ready         = (state_reg == S_IDLE);
    assign out_valid        = out_valid_reg;
    assign status           = out_status_reg;
    assign dispatched       = out_disp_reg;
    assign run_task_id      = out_id_reg;
    assign running_priority = out_level_reg;
    assign queued_count     = out_count_reg;

    // Checks
    `PPTQ_ASSERT_NEVER(a_count_range, count_reg > QCNT_W'(QUEUE_DEPTH), "queue count overflow")
    `PPTQ_ASSERT_NEVER(a_nest_range, nest_reg > NCNT_W'(NEST_DEPTH), "nesting depth overflow")
    `PPTQ_ASSERT(a_one_at_a_time, (in_valid && in_ready) |=> !in_ready, "second command taken")
    `PPTQ_ASSERT(a_disp_status, (out_valid && dispatched) |-> (status == ST_DONE), "bad status")
    `PPTQ_ASSERT(a_idle_id, (out_valid && !dispatched) |-> (run_task_id == '0), "stray task id")

endmodule

// ===== tb/sv/pptq_response_checker.sv =====
// Response checker for the preemptive priority task queue: watches both channels,
// keeps its own model of the wait queue and nesting stack, and compares every result.
// Depends on pptq_pkg.
`timescale 1ns / 1ps

module pptq_response_checker
    import pptq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [1:0]           cmd,
    input  logic [TASK_W-1:0]    task_id,
    input  logic [LEVEL_W-1:0]   task_priority,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [1:0]           status,
    input  logic                 dispatched,
    input  logic [TASK_W-1:0]    run_task_id,
    input  logic [LEVEL_W-1:0]   running_priority,
    input  logic [CNT_OUT_W-1:0] queued_count,
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        status_t              status;
        logic                 dispatched;
        logic [TASK_W-1:0]    run_id;
        logic [LEVEL_W-1:0]   level;
        logic [CNT_OUT_W-1:0] count;
    } queue_response_t;

    // Model state: sorted wait queue, running level, nesting stack
    logic [LEVEL_W-1:0] wait_prio [QUEUE_DEPTH];
    logic [TASK_W-1:0]  wait_id   [QUEUE_DEPTH];
    int                 wait_count;
    logic [LEVEL_W-1:0] run_level;
    logic [LEVEL_W-1:0] saved_level [NEST_DEPTH];
    int                 nest_depth;

    queue_response_t pending_responses[$];
    int              errors;
    int              beats_out;

    task automatic report_error(input string msg);
        $display("%0t ns: result beat %0d: %s", $time, beats_out, msg);
        errors++;
    endtask

    // Applies one command beat to the model and returns the response it gives
    function automatic queue_response_t predict_queue_response(
        input cmd_t               op,
        input logic [TASK_W-1:0]  id,
        input logic [LEVEL_W-1:0] prio
    );
        queue_response_t r;
        int              pos;
        int              k;
        r        = '0;
        r.status = ST_DONE;
        case (op)
            CMD_ADD:
            begin
                if (wait_count >= QUEUE_DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    // insert behind every entry of equal or more urgent priority
                    pos = 0;
                    while (pos < wait_count && wait_prio[pos] <= prio)
                        pos++;
                    for (k = wait_count; k > pos; k--)
                    begin
                        wait_prio[k] = wait_prio[k-1];
                        wait_id[k]   = wait_id[k-1];
                    end
                    wait_prio[pos] = prio;
                    wait_id[pos]   = id;
                    wait_count++;
                end
            end
            CMD_DISPATCH:
            begin
                if (wait_count == 0 || wait_prio[0] >= run_level)
                begin
                    r.status = ST_NONE;
                end
                else if (nest_depth >= NEST_DEPTH)
                begin
                    r.status = ST_NEST;
                end
                else
                begin
                    // preempt: save running level, head becomes the running task
                    saved_level[nest_depth] = run_level;
                    nest_depth++;
                    run_level    = wait_prio[0];
                    r.dispatched = 1'b1;
                    r.run_id     = wait_id[0];
                    for (k = 1; k < wait_count; k++)
                    begin
                        wait_prio[k-1] = wait_prio[k];
                        wait_id[k-1]   = wait_id[k];
                    end
                    wait_count--;
                end
            end
            CMD_FINISH:
            begin
                if (nest_depth == 0)
                begin
                    r.status = ST_NEST;
                end
                else
                begin
                    nest_depth--;
                    run_level = saved_level[nest_depth];
                end
            end
            default:
            begin
                // unused code: no operation
            end
        endcase
        r.level = run_level;
        r.count = CNT_OUT_W'(wait_count);
        return r;
    endfunction

    // Predict on each accepted command beat, compare on each accepted result beat
    always @(posedge clk or negedge rst_n)
    begin
        queue_response_t want;
        if (!rst_n)
        begin
            wait_count = 0;
            nest_depth = 0;
            run_level  = IDLE_LEVEL;
            errors     = 0;
            beats_out  = 0;
            pending_responses.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                pending_responses.push_back(
                    predict_queue_response(cmd_t'(cmd), task_id, task_priority));

            if (out_valid && out_ready)
            begin
                if (pending_responses.size() == 0)
                begin
                    report_error($sformatf("unexpected result, status %0d", status));
                end
                else
                begin
                    want = pending_responses.pop_front();
                    if (status !== want.status)
                        report_error($sformatf("status %0d, expected %0d",
                                               status, want.status));
                    if (dispatched !== want.dispatched)
                        report_error($sformatf("dispatched %0d, expected %0d",
                                               dispatched, want.dispatched));
                    if (run_task_id !== want.run_id)
                        report_error($sformatf("run_task_id %0d, expected %0d",
                                               run_task_id, want.run_id));
                    if (running_priority !== want.level)
                        report_error($sformatf("running_priority %0d, expected %0d",
                                               running_priority, want.level));
                    if (queued_count !== want.count)
                        report_error($sformatf("queued_count %0d, expected %0d",
                                               queued_count, want.count));
                end
                beats_out++;
            end

            fail_count <= errors;
            pending    <= pending_responses.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the preemptive priority task queue: clock, reset, command stimulus,
// result back-pressure and the verdict. Depends on pptq_pkg, the block and pptq_response_checker.
`timescale 1ns / 1ps

module tb;
    import pptq_pkg::*;

    localparam int unsigned NUM_BEATS = 1850;

    logic                 clk;
    logic                 rst_n         = 1'b0;
    logic                 in_valid      = 1'b0;
    logic                 in_ready;
    logic [1:0]           cmd           = CMD_NOP;
    logic [TASK_W-1:0]    task_id       = '0;
    logic [LEVEL_W-1:0]   task_priority = '0;
    logic                 out_valid;
    logic                 out_ready     = 1'b0;
    logic [1:0]           status;
    logic                 dispatched;
    logic [TASK_W-1:0]    run_task_id;
    logic [LEVEL_W-1:0]   running_priority;
    logic [CNT_OUT_W-1:0] queued_count;

    int          fail_count;
    int          pending;
    int unsigned beats_sent = 0;
    logic        calm       = 1'b0;

    preemptive_priority_task_queue i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .cmd              (cmd),
        .task_id          (task_id),
        .task_priority    (task_priority),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .dispatched       (dispatched),
        .run_task_id      (run_task_id),
        .running_priority (running_priority),
        .queued_count     (queued_count)
    );

    pptq_response_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .cmd              (cmd),
        .task_id          (task_id),
        .task_priority    (task_priority),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .dispatched       (dispatched),
        .run_task_id      (run_task_id),
        .running_priority (running_priority),
        .queued_count     (queued_count),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Result side stalls at random, about 13 percent of the time, never during the calm stretch
    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(0, 99) >= 13);
    end

    // Drives one command beat and holds it until accepted, then maybe leaves a gap
    task automatic send_beat(
        input cmd_t               op,
        input logic [TASK_W-1:0]  id,
        input logic [LEVEL_W-1:0] prio
    );
        in_valid      <= 1'b1;
        cmd           <= op;
        task_id       <= id;
        task_priority <= prio;
        do @(posedge clk); while (!in_ready);
        beats_sent++;
        calm <= (beats_sent >= 700 && beats_sent < 1000);
        if (!(beats_sent >= 700 && beats_sent < 1000) && $urandom_range(0, 99) < 13)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    endtask

    // Holds off the command side until every result has come back
    task automatic wait_all_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic logic [7:0] rand_byte();
        return 8'($urandom());
    endfunction

    // Stimulus
    initial
    begin
        int                 k;
        int unsigned        n;
        int unsigned        pick;
        int unsigned        step;
        logic [LEVEL_W-1:0] lvl;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: error paths on an empty block
        send_beat(CMD_FINISH, 8'h00, 8'h00);       // finish with nothing running
        send_beat(CMD_DISPATCH, 8'hFF, 8'hFF);     // dispatch from an empty queue
        send_beat(CMD_NOP, 8'h5A, 8'hA5);          // unused code
        // equal priorities leave in arrival order
        send_beat(CMD_ADD, 8'h00, 8'd254);
        send_beat(CMD_ADD, 8'hA5, 8'd254);
        send_beat(CMD_DISPATCH, 8'h00, 8'h00);
        send_beat(CMD_DISPATCH, 8'hFF, 8'hFF);     // head not strictly more urgent
        // nest down to a full stack
        for (k = 7; k >= 1; k--)
        begin
            send_beat(CMD_ADD, 8'(8'h10 + k), 8'(k));
            send_beat(CMD_DISPATCH, rand_byte(), rand_byte());
        end
        send_beat(CMD_ADD, 8'hFF, 8'd0);
        send_beat(CMD_DISPATCH, 8'h00, 8'h00);     // nesting stack full
        send_beat(CMD_ADD, 8'h3C, IDLE_LEVEL);     // idle-level task, never dispatchable
        wait_all_results();

        // Random sequences
        while (beats_sent < NUM_BEATS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                // noise: any command, random fields
                repeat ($urandom_range(1, 6))
                begin
                    if ($urandom_range(0, 29) == 0)
                        send_beat(CMD_NOP, rand_byte(), rand_byte());
                    else
                        send_beat(cmd_t'($urandom_range(0, 2)), rand_byte(),
                                  8'($urandom_range(0, 254)));
                end
            end
            else if (pick < 45)
            begin
                // preemption chain: ever more urgent tasks, then unwind
                n   = $urandom_range(1, 10);
                lvl = 8'($urandom_range(120, 254));
                repeat (n)
                begin
                    step = $urandom_range(1, 12);
                    lvl  = (lvl > step) ? 8'(lvl - step) : 8'd0;
                    send_beat(CMD_ADD, rand_byte(), lvl);
                    send_beat(CMD_DISPATCH, rand_byte(), rand_byte());
                end
                repeat (n + $urandom_range(0, 2))
                    send_beat(CMD_FINISH, rand_byte(), rand_byte());
            end
            else if (pick < 70)
            begin
                // fill: mix of tied and spread priorities
                repeat ($urandom_range(4, 20))
                begin
                    if ($urandom_range(0, 1) == 0)
                        lvl = 8'($urandom_range(0, 254));
                    else
                        lvl = 8'($urandom_range(0, 3) * 60 + 10);
                    send_beat(CMD_ADD, rand_byte(), lvl);
                end
            end
            else
            begin
                // drain: run a task and finish it
                repeat ($urandom_range(2, 16))
                begin
                    send_beat(CMD_DISPATCH, rand_byte(), rand_byte());
                    send_beat(CMD_FINISH, rand_byte(), rand_byte());
                end
            end
            if ($urandom_range(0, 29) == 0)
                wait_all_results();
        end

        // Let everything settle before the verdict
        wait_all_results();
        repeat (2 * QUEUE_DEPTH + 8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[preemptive_priority_task_queue] OK");
        else
            $display("[preemptive_priority_task_queue] ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("[preemptive_priority_task_queue] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/pptq_pkg.sv
hw/rtl/preemptive_priority_task_queue.sv
tb/sv/pptq_response_checker.sv
tb/sv/tb.sv
